FILE: sv/qbve_pkg.sv
// Shared types and constants of the quad batch vertex expander.
// Holds the operation codes, the stream field layout and the
// controller/datapath command and status words. No dependencies.
`timescale 1ns / 1ps

package qbve_pkg;

  // Default sizes of the batch and of the texture slot table
  localparam int BATCH_QUADS_DEF      = 1024;
  localparam int SLOT_TABLE_DEPTH_DEF = 31;

  // Input stream layout
  localparam int S_DATA_W = 184;
  localparam int S_USER_W = 2;

  // Output stream layout
  localparam int M_DATA_W = 112;
  localparam int M_USER_W = 2;
  localparam int M_PAD_W  = 6;

  // Field widths
  localparam int COORD_W = 16;
  localparam int VERT_W  = 17;
  localparam int COLOR_W = 24;
  localparam int TEXID_W = 32;
  localparam int TEXC_W  = 16;
  localparam int SLOT_W  = 5;
  localparam int BQ_W    = 11;

  // Texture and color constants
  localparam logic [TEXC_W-1:0]  TEX_ONE = 16'h8000;
  localparam logic [TEXC_W-1:0]  TEX_MAX = 16'hFFFF;
  localparam logic [COLOR_W-1:0] WHITE   = 24'hFFFFFF;

  // Corner numbering: 0 top-left, 1 top-right, 2 bottom-right, 3 bottom-left
  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef enum logic [1:0] {
    OP_COLOR   = 2'd0,
    OP_TEXTURE = 2'd1,
    OP_END     = 2'd2
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;       // capture the accepted input word
    logic       scan_step;  // read the next slot table entry
    logic       take_hit;   // use the entry under compare
    logic       take_miss;  // bind the texture into the next free slot
    logic       emit;       // load one vertex into the output register
    logic [1:0] corner;     // corner of the vertex being emitted
    logic       emit_end;   // load the end-of-batch word
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic match;     // entry under compare holds the texture
    logic scan_end;  // every bound slot has been read
    logic out_free;  // output register can take a word this cycle
  } sts_t;

endpackage

FILE: sv/quad_batch_vertex_expander_unit.sv
// Quad batch vertex expander: expands colored and textured quads into four
// corner vertices and tracks batches. Top level; uses qbve_pkg, qbve_ctrl
// and qbve_datapath.
//
// Usage:
//   The input stream carries one command per word: a colored quad, a
//   textured quad or an end-of-batch request (operation in tuser). Each quad
//   yields four vertex words, tlast on the fourth; an end-of-batch request
//   yields one word with the flush flag set. The flush flag and quad count
//   also ride on the fourth vertex when the batch or the slot table fills up.
//   Sequence: after a word is taken, a colored quad emits its four vertices
//   in corner order, each once the output register is free. A textured quad
//   first scans the slot table memory one entry per cycle up to a hit or, for
//   a miss, until every bound slot is read; the single read port of the table
//   sets this pace. An end-of-batch request emits its word once the output
//   register is free; a reserved operation is taken with no output.
//   The output register holds one word; when the receiver stalls, emission
//   waits and the next input is taken once the last word is registered.
//   Reset clears the batch: quad count and slot count go to zero.
`timescale 1ns / 1ps

module quad_batch_vertex_expander_unit
  import qbve_pkg::*;
#(
  parameter int BATCH_QUADS      = BATCH_QUADS_DEF,
  parameter int SLOT_TABLE_DEPTH = SLOT_TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // pos_x, pos_y, quad_width, quad_height, fill_color, texture_id,
  // tex_left, tex_top, tex_span_x, tex_span_y
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // operation
  input  logic [S_USER_W-1:0] s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // vertex_x, vertex_y, vertex_color, vertex_u, vertex_v, slot index,
  // batch_quads, zero padding
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  // new_binding, batch_flush
  output logic [M_USER_W-1:0] m_axis_tuser_o,
  // last
  output logic                m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;

  qbve_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  qbve_datapath #(
    .BATCH_QUADS      (BATCH_QUADS),
    .SLOT_TABLE_DEPTH (SLOT_TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

FILE: sv/qbve_ctrl.sv
// Controller of the quad batch vertex expander.
// Sequences accept, slot table scan and vertex emission; uses qbve_pkg.
`timescale 1ns / 1ps

module qbve_ctrl
  import qbve_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic [S_USER_W-1:0] s_axis_tuser_i,
  output logic                s_axis_tready_o,
  input  sts_t                sts_i,
  output cmd_t                cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_VERT = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] corner_q, corner_d;
  op_e        op_in;

  assign op_in = op_e'(s_axis_tuser_i);

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    corner_d        = corner_q;
    s_axis_tready_o = 1'b0;
    cmd_o           = '0;
    cmd_o.corner    = corner_q;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          corner_d   = CORNER_TL;
          unique case (op_in)
            OP_COLOR:   state_d = S_VERT;
            OP_TEXTURE: state_d = S_SCAN;
            OP_END:     state_d = S_END;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        priority if (sts_i.match) begin
          cmd_o.take_hit = 1'b1;
          state_d        = S_VERT;
        end else if (sts_i.scan_end) begin
          cmd_o.take_miss = 1'b1;
          state_d         = S_VERT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_VERT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (corner_q == CORNER_BL) begin
            state_d = S_IDLE;
          end else begin
            corner_d = corner_q + 2'd1;
          end
        end
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      corner_q <= CORNER_TL;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
    end
  end

endmodule

FILE: sv/qbve_datapath.sv
// Datapath of the quad batch vertex expander: input registers, slot table
// memory with scan compare, batch counters and the output register.
// Uses qbve_pkg; driven by qbve_ctrl commands.
`timescale 1ns / 1ps

module qbve_datapath
  import qbve_pkg::*;
#(
  parameter int BATCH_QUADS      = BATCH_QUADS_DEF,
  parameter int SLOT_TABLE_DEPTH = SLOT_TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  input  logic [S_USER_W-1:0] s_axis_tuser_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                m_axis_tready_i,
  output logic                m_axis_tvalid_o,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  output logic [M_USER_W-1:0] m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  localparam int QCW = $clog2(BATCH_QUADS + 1);
  localparam int SCW = $clog2(SLOT_TABLE_DEPTH + 1);
  localparam int AW  = (SLOT_TABLE_DEPTH > 1) ? $clog2(SLOT_TABLE_DEPTH) : 1;

  // Captured input word
  op_e                        op_q;
  logic signed [COORD_W-1:0]  pos_x_q, pos_y_q, quad_w_q, quad_h_q;
  logic [COLOR_W-1:0]         color_q;
  logic [TEXID_W-1:0]         tex_id_q;
  logic [TEXC_W-1:0]          tex_l_q, tex_t_q, span_x_q, span_y_q;

  // Batch state
  logic [QCW-1:0]             quad_count_q;
  logic [SCW-1:0]             slot_count_q;

  // Scan state
  logic [TEXID_W-1:0]         slot_mem [SLOT_TABLE_DEPTH];
  logic [TEXID_W-1:0]         rd_q;
  logic [SCW-1:0]             idx_q, cmp_idx_q, slot_idx_q;
  logic                       cmp_v_q, fresh_q;

  // Output register
  logic                       m_valid_q;
  logic [M_DATA_W-1:0]        m_data_q;
  logic [M_USER_W-1:0]        m_user_q;
  logic                       m_last_q;

  // Vertex arithmetic
  logic                       is_tex, full_tex, batch_full, slots_full, flush;
  logic signed [VERT_W-1:0]   x0, y0, x1, y1, vx, vy;
  logic [TEXC_W-1:0]          ul, vt, sx, sy, u_far, v_far, vu, vv;
  logic [TEXC_W:0]            u_sum, v_sum;
  logic [COLOR_W-1:0]         vcolor;
  logic [SLOT_W-1:0]          vslot;
  logic [SCW:0]               slot_wide;
  logic [QCW-1:0]             qc_inc;

  assign is_tex   = (op_q == OP_TEXTURE);
  assign full_tex = (span_x_q == '0) || (span_y_q == '0);

  assign x0 = VERT_W'(pos_x_q);
  assign y0 = VERT_W'(pos_y_q);
  assign x1 = x0 + VERT_W'(quad_w_q);
  assign y1 = y0 + VERT_W'(quad_h_q);

  // Texture origin and span: zero for a colored quad, full texture when a span is zero
  always_comb begin
    if (!is_tex) begin
      ul = '0;
      vt = '0;
      sx = '0;
      sy = '0;
    end else if (full_tex) begin
      ul = '0;
      vt = '0;
      sx = TEX_ONE;
      sy = TEX_ONE;
    end else begin
      ul = tex_l_q;
      vt = tex_t_q;
      sx = span_x_q;
      sy = span_y_q;
    end
  end

  // Saturate the far texture edges
  assign u_sum = {1'b0, ul} + {1'b0, sx};
  assign v_sum = {1'b0, vt} + {1'b0, sy};
  assign u_far = u_sum[TEXC_W] ? TEX_MAX : u_sum[TEXC_W-1:0];
  assign v_far = v_sum[TEXC_W] ? TEX_MAX : v_sum[TEXC_W-1:0];

  // Pick the corner
  always_comb begin
    unique case (cmd_i.corner)
      CORNER_TL: begin vx = x0; vy = y0; vu = ul;    vv = vt;    end
      CORNER_TR: begin vx = x1; vy = y0; vu = u_far; vv = vt;    end
      CORNER_BR: begin vx = x1; vy = y1; vu = u_far; vv = v_far; end
      CORNER_BL: begin vx = x0; vy = y1; vu = ul;    vv = v_far; end
      default:   begin vx = x0; vy = y0; vu = ul;    vv = vt;    end
    endcase
  end

  assign slot_wide = {1'b0, slot_idx_q} + (SCW + 1)'(1);
  assign vslot     = is_tex ? SLOT_W'(slot_wide) : '0;
  assign vcolor    = is_tex ? WHITE : color_q;

  // Batch limits, checked on the last corner of a quad
  assign qc_inc     = quad_count_q + QCW'(1);
  assign batch_full = (qc_inc >= QCW'(BATCH_QUADS));
  assign slots_full = is_tex && (slot_count_q >= SCW'(SLOT_TABLE_DEPTH));
  assign flush      = batch_full || slots_full;

  // Status to the controller
  assign sts_o.match    = cmp_v_q && (rd_q == tex_id_q);
  assign sts_o.scan_end = (idx_q >= slot_count_q);
  assign sts_o.out_free = !m_valid_q || m_axis_tready_i;

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(s_axis_tuser_i);
      pos_x_q  <= s_axis_tdata_i[15:0];
      pos_y_q  <= s_axis_tdata_i[31:16];
      quad_w_q <= s_axis_tdata_i[47:32];
      quad_h_q <= s_axis_tdata_i[63:48];
      color_q  <= s_axis_tdata_i[87:64];
      tex_id_q <= s_axis_tdata_i[119:88];
      tex_l_q  <= s_axis_tdata_i[135:120];
      tex_t_q  <= s_axis_tdata_i[151:136];
      span_x_q <= s_axis_tdata_i[167:152];
      span_y_q <= s_axis_tdata_i[183:168];
    end
  end

  // Slot table memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_miss && (slot_count_q < SCW'(SLOT_TABLE_DEPTH))) begin
      slot_mem[slot_count_q[AW-1:0]] <= tex_id_q;
    end
    rd_q <= slot_mem[idx_q[AW-1:0]];
  end

  // Scan pointer and slot selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      cmp_idx_q  <= '0;
      cmp_v_q    <= 1'b0;
      slot_idx_q <= '0;
      fresh_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q   <= '0;
        cmp_v_q <= 1'b0;
        fresh_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        idx_q     <= idx_q + SCW'(1);
        cmp_idx_q <= idx_q;
        cmp_v_q   <= 1'b1;
      end
      if (cmd_i.take_hit) begin
        slot_idx_q <= cmp_idx_q;
        fresh_q    <= 1'b0;
      end
      if (cmd_i.take_miss) begin
        slot_idx_q <= slot_count_q;
        fresh_q    <= 1'b1;
      end
    end
  end

  // Batch counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_count_q <= '0;
      slot_count_q <= '0;
    end else begin
      if (cmd_i.take_miss && (slot_count_q < SCW'(SLOT_TABLE_DEPTH))) begin
        slot_count_q <= slot_count_q + SCW'(1);
      end
      if (cmd_i.emit && (cmd_i.corner == CORNER_BL)) begin
        if (flush) begin
          quad_count_q <= '0;
          slot_count_q <= '0;
        end else begin
          quad_count_q <= qc_inc;
        end
      end
      if (cmd_i.emit_end) begin
        quad_count_q <= '0;
        slot_count_q <= '0;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_end) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cmd_i.corner == CORNER_BL) begin
        m_data_q <= {M_PAD_W'(0), (flush ? BQ_W'(qc_inc) : BQ_W'(0)),
                     vslot, vv, vu, vcolor, vy, vx};
        m_user_q <= {flush, 1'b0};
        m_last_q <= 1'b1;
      end else begin
        m_data_q <= {M_PAD_W'(0), BQ_W'(0), vslot, vv, vu, vcolor, vy, vx};
        m_user_q <= {1'b0, (cmd_i.corner == CORNER_TL) && is_tex && fresh_q};
        m_last_q <= 1'b0;
      end
    end else if (cmd_i.emit_end) begin
      m_data_q <= {M_PAD_W'(0), BQ_W'(quad_count_q),
                   (M_DATA_W - M_PAD_W - BQ_W)'(0)};
      m_user_q <= 2'b10;
      m_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule
